/* rtl/fpn_pkg.sv */
package fpn_pkg;

	// permutation table geometry
	localparam int MAX_OCT = 8;
	localparam int OCT_W   = 3;
	localparam int IDX_W   = 8;
	localparam int ADDR_W  = OCT_W + IDX_W;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 21;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// final divider widths
	localparam int NUM_W = 38;
	localparam int DEN_W = 25;
	localparam int QUO_W = 10;
	localparam int CNT_W = 4;

	// configuration register indexes
	localparam logic CFG_SCALE   = 1'b0;
	localparam logic CFG_OCTAVES = 1'b1;

	// request function codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;

	typedef logic [ADDR_W-1:0] perm_addr_t;
	typedef logic [IDX_W-1:0]  perm_data_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* rtl/fpn_perm_mem.sv */
module fpn_perm_mem (
	input  logic                clk,
	input  logic                we,
	input  fpn_pkg::perm_addr_t waddr,
	input  fpn_pkg::perm_data_t wdata,
	input  fpn_pkg::perm_addr_t raddr,
	output fpn_pkg::perm_data_t rdata
);

	fpn_pkg::perm_data_t mem [2**fpn_pkg::ADDR_W];
	fpn_pkg::perm_data_t rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/fpn_mul_unit.sv */
module fpn_mul_unit (
	input  logic                                clk,
	input  logic signed [fpn_pkg::MUL_A_W-1:0] a,
	input  logic signed [fpn_pkg::MUL_B_W-1:0] b,
	output logic signed [fpn_pkg::PROD_W-1:0]  prod
);

	logic signed [fpn_pkg::PROD_W-1:0] prod_q;

	// signed product, registered before any use
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

/* rtl/fpn_div_unit.sv */
module fpn_div_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fpn_pkg::NUM_W-1:0]  num,
	input  logic [fpn_pkg::DEN_W-1:0]  den,
	output logic [fpn_pkg::QUO_W-1:0]  quo,
	output fpn_pkg::div_stat_t         stat
);

	logic [fpn_pkg::NUM_W-1:0] rem_q;
	logic [fpn_pkg::DEN_W-1:0] den_q;
	logic [fpn_pkg::QUO_W-1:0] quo_q;
	logic [fpn_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [fpn_pkg::NUM_W-1:0] trial;
	logic                      fits;

	// divisor aligned to the current quotient bit
	assign trial = fpn_pkg::NUM_W'(den_q) << cnt_q;
	assign fits  = rem_q >= trial;

	// restoring division, one quotient bit per cycle, msb first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= fpn_pkg::CNT_W'(fpn_pkg::QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// remainder and quotient datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - trial;
			end
			quo_q <= {quo_q[fpn_pkg::QUO_W-2:0], fits};
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* rtl/fractal_perlin_noise_pixel_top.sv */
// 2D fractal Perlin noise, one 8-bit pixel per request.
// Configuration: cfg_we writes cfg_data into register cfg_index (0: scale_q16,
// 1: octave_count) at once; write only while no request is in flight.
// Input channel in_valid/in_ready: func 0 writes one permutation table entry
// (table_octave, table_index, table_value) and gives no result;
// func 1 computes the pixel at (pixel_x, pixel_y) and gives one pixel_value.
// Per pixel, each octave in turn uses the shared multiplier for nine
// products (two fades, three lerps) and the table's single read port for six
// lookups, then a bit-serial divider with a 10-bit quotient normalizes the
// weighted sum. in_ready is low until the result enters the output stage.
// Output channel out_valid/out_ready: the result sits in an output register,
// so the next request is taken while an earlier pixel still waits; a pixel
// finished while the register is full waits until the receiver takes the old
// one. Reset sets scale_q16 to 3277 and octave_count to 4 and empties the
// output register; the permutation tables hold nothing until loaded.
module fractal_perlin_noise_pixel_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [2:0]  table_octave,
	input  logic [7:0]  table_index,
	input  logic [7:0]  table_value,
	input  logic [13:0] pixel_x,
	input  logic [13:0] pixel_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  pixel_value
);

	localparam int   LW          = 20;
	localparam int   ACC_W       = 30;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SY, ST_SY2,
		ST_FX0, ST_FX1, ST_FX2, ST_FX3,
		ST_FY0, ST_FY1, ST_FY2, ST_FY3,
		ST_L0, ST_L1, ST_L2, ST_L3, ST_L4,
		ST_SUM, ST_DIV_START, ST_DIV_WAIT, ST_OUT
	} state_t;

	state_t      state_q;
	logic [16:0] scale_q;
	logic [3:0]  octcnt_q;
	logic [3:0]  n_q;
	logic [2:0]  oct_q;
	logic        out_valid_q;
	logic [7:0]  pixel_q;
	logic [7:0]  res_q;

	// datapath registers
	logic [13:0]             py_in_q;
	logic [30:0]             sxp_q;
	logic [30:0]             syp_q;
	logic [19:0]             q16_q;
	logic [16:0]             u_q;
	logic [16:0]             v_q;
	logic [7:0]              ha_q, hb_q, aa_q, ab_q, ba_q, bb_q;
	logic signed [LW-1:0]    x1_q, x2_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [7:0]              w_q;
	logic signed [30:0]      s_q;

	logic signed [fpn_pkg::MUL_A_W-1:0] mul_a;
	logic signed [fpn_pkg::MUL_B_W-1:0] mul_b;
	logic signed [fpn_pkg::PROD_W-1:0]  prod;

	fpn_pkg::perm_addr_t raddr;
	fpn_pkg::perm_data_t rdata;
	logic                mem_we;

	logic                      div_start;
	logic [fpn_pkg::NUM_W-1:0] div_num;
	logic [fpn_pkg::DEN_W-1:0] div_den;
	logic [fpn_pkg::QUO_W-1:0] div_quo;
	fpn_pkg::div_stat_t        div_stat;

	logic        accept;
	logic        fade_y;
	logic [30:0] sxo, syo;
	logic [7:0]  xi, yi;
	logic [15:0] xf, yf, t;
	logic [36:0] q_sum;
	logic [48:0] t3_sum;
	logic [36:0] f_sum;
	logic [20:0] f_val;
	logic [16:0] f_lim;
	logic signed [fpn_pkg::PROD_W-1:0] rnd;
	logic signed [LW-1:0] rs;
	logic signed [17:0] x0s, x1s, y0s, y1s;
	logic signed [18:0] g_aa, g_ba, g_ab, g_bb;
	logic signed [LW-1:0] noise;
	logic signed [ACC_W-1:0] noise_ext;
	logic [2:0]  wsh;
	logic [3:0]  n_clamp;
	logic        last_oct;

	// gradient: sign-combined sum of the two offsets picked by the hash
	function automatic logic signed [18:0] grad(input logic [7:0] h,
		input logic signed [17:0] x, input logic signed [17:0] y);
		logic signed [18:0] a;
		logic signed [18:0] b;
		begin
			a = h[1] ? 19'(y) : 19'(x);
			b = h[1] ? 19'(x) : 19'(y);
			grad = (h[0] ? -a : a) + (h[1] ? -b : b);
		end
	endfunction

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign mem_we    = accept && (func == fpn_pkg::FUNC_WRITE);
	assign out_valid = out_valid_q;
	assign pixel_value = pixel_q;

	// sample position for the current octave
	assign sxo = sxp_q << oct_q;
	assign syo = syp_q << oct_q;
	assign xi  = sxo[23:16];
	assign yi  = syo[23:16];
	assign xf  = sxo[15:0];
	assign yf  = syo[15:0];

	assign fade_y = (state_q == ST_FY0) || (state_q == ST_FY1) ||
		(state_q == ST_FY2) || (state_q == ST_FY3);
	assign t = fade_y ? yf : xf;

	// fade steps: q = 6t^2 - 15t + 10, t^3 and their product, half-up rounding
	assign q_sum  = (37'(10) << 32) + (37'(prod[31:0]) << 2) + (37'(prod[31:0]) << 1)
		- (37'(t) << 20) + (37'(t) << 16) + 37'd32768;
	assign t3_sum = prod[48:0] + 49'h0_8000_0000;
	assign f_sum  = prod[36:0] + 37'd32768;
	assign f_val  = f_sum[36:16];
	assign f_lim  = (f_val > 21'd65536) ? 17'd65536 : f_val[16:0];

	// lerp rounding of the last product
	assign rnd = prod + fpn_pkg::PROD_W'(32768);
	assign rs  = rnd[16+LW-1:16];

	// corner offsets and gradients
	assign x0s  = {2'b00, xf};
	assign x1s  = {2'b00, xf} - 18'sd65536;
	assign y0s  = {2'b00, yf};
	assign y1s  = {2'b00, yf} - 18'sd65536;
	assign g_aa = grad(aa_q, x0s, y0s);
	assign g_ba = grad(ba_q, x1s, y0s);
	assign g_ab = grad(ab_q, x0s, y1s);
	assign g_bb = grad(bb_q, x1s, y1s);

	// octave weight and accumulation term
	assign wsh       = 3'(fpn_pkg::MAX_OCT - 1) - oct_q;
	assign noise     = x1_q + rs;
	assign noise_ext = {{(ACC_W-LW){noise[LW-1]}}, noise} <<< wsh;
	assign last_oct  = ({1'b0, oct_q} + 4'd1) == n_q;

	assign n_clamp = (octcnt_q == 4'd0) ? 4'd1 :
		(octcnt_q > 4'(fpn_pkg::MAX_OCT)) ? 4'(fpn_pkg::MAX_OCT) : octcnt_q;

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_IDLE: begin
				mul_a = {16'b0, scale_q};
				mul_b = {7'b0, pixel_x};
			end
			ST_SY: begin
				mul_a = {16'b0, scale_q};
				mul_b = {7'b0, py_in_q};
			end
			ST_FX0, ST_FY0: begin
				mul_a = {17'b0, t};
				mul_b = {5'b0, t};
			end
			ST_FX1, ST_FY1: begin
				mul_a = {1'b0, prod[31:0]};
				mul_b = {5'b0, t};
			end
			ST_FX2, ST_FY2: begin
				mul_a = {16'b0, t3_sum[48:32]};
				mul_b = {1'b0, q16_q};
			end
			ST_L0: begin
				mul_a = fpn_pkg::MUL_A_W'(LW'(g_ba) - LW'(g_aa));
				mul_b = {4'b0, u_q};
			end
			ST_L1: begin
				mul_a = fpn_pkg::MUL_A_W'(LW'(g_bb) - LW'(g_ab));
				mul_b = {4'b0, u_q};
			end
			ST_L3: begin
				mul_a = fpn_pkg::MUL_A_W'(x2_q - x1_q);
				mul_b = {4'b0, v_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// table read address select
	always_comb begin
		case (state_q)
			ST_FX0:  raddr = {oct_q, xi};
			ST_FX1:  raddr = {oct_q, xi + 8'd1};
			ST_FX2:  raddr = {oct_q, ha_q + yi};
			ST_FX3:  raddr = {oct_q, ha_q + yi + 8'd1};
			ST_FY0:  raddr = {oct_q, hb_q + yi};
			ST_FY1:  raddr = {oct_q, hb_q + yi + 8'd1};
			default: raddr = '0;
		endcase
	end

	// divider operands: (s * 255) / (w * 2^17)
	assign div_start = (state_q == ST_DIV_START) && (s_q > 31'sd0);
	assign div_num   = {s_q[29:0], 8'b0} - {7'b0, s_q};
	assign div_den   = {w_q, 17'b0};

	fpn_perm_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr ({table_octave, table_index}),
		.wdata (table_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	fpn_mul_unit u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	fpn_div_unit u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.stat   (div_stat)
	);

	// sequencer, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scale_q     <= 17'd3277;
			octcnt_q    <= 4'd4;
			n_q         <= 4'd1;
			oct_q       <= '0;
			out_valid_q <= 1'b0;
			pixel_q     <= '0;
			res_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					fpn_pkg::CFG_SCALE:   scale_q  <= cfg_data;
					fpn_pkg::CFG_OCTAVES: octcnt_q <= cfg_data[3:0];
					default:              scale_q  <= scale_q;
				endcase
			end
			if (out_valid_q && out_ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (func == fpn_pkg::FUNC_PIXEL)) begin
						n_q     <= n_clamp;
						oct_q   <= '0;
						state_q <= ST_SY;
					end
				end
				ST_SY:   state_q <= ST_SY2;
				ST_SY2:  state_q <= ST_FX0;
				ST_FX0:  state_q <= ST_FX1;
				ST_FX1:  state_q <= ST_FX2;
				ST_FX2:  state_q <= ST_FX3;
				ST_FX3:  state_q <= ST_FY0;
				ST_FY0:  state_q <= ST_FY1;
				ST_FY1:  state_q <= ST_FY2;
				ST_FY2:  state_q <= ST_FY3;
				ST_FY3:  state_q <= ST_L0;
				ST_L0:   state_q <= ST_L1;
				ST_L1:   state_q <= ST_L2;
				ST_L2:   state_q <= ST_L3;
				ST_L3:   state_q <= ST_L4;
				ST_L4: begin
					if (last_oct) begin
						state_q <= ST_SUM;
					end else begin
						oct_q   <= oct_q + 3'd1;
						state_q <= ST_FX0;
					end
				end
				ST_SUM:  state_q <= ST_DIV_START;
				ST_DIV_START: begin
					if (s_q > 31'sd0) begin
						state_q <= ST_DIV_WAIT;
					end else begin
						res_q   <= 8'd0;
						state_q <= ST_OUT;
					end
				end
				ST_DIV_WAIT: begin
					if (div_stat.done) begin
						res_q   <= (div_quo > 10'd255) ? 8'd255 : div_quo[7:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						pixel_q     <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-pixel datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				py_in_q <= pixel_y;
				acc_q   <= '0;
				w_q     <= '0;
			end
			ST_SY:  sxp_q <= prod[30:0];
			ST_SY2: syp_q <= prod[30:0];
			ST_FX1: begin
				q16_q <= q_sum[35:16];
				ha_q  <= rdata;
			end
			ST_FX2: hb_q <= rdata;
			ST_FX3: begin
				u_q  <= f_lim;
				aa_q <= rdata;
			end
			ST_FY0: ab_q <= rdata;
			ST_FY1: begin
				q16_q <= q_sum[35:16];
				ba_q  <= rdata;
			end
			ST_FY2: bb_q <= rdata;
			ST_FY3: v_q <= f_lim;
			ST_L1:  x1_q <= LW'(g_aa) + rs;
			ST_L2:  x2_q <= LW'(g_ab) + rs;
			ST_L4: begin
				acc_q <= acc_q + noise_ext;
				w_q   <= w_q + (8'd1 << wsh);
			end
			ST_SUM: s_q <= 31'(acc_q) + $signed({7'b0, w_q, 16'b0});
			default: acc_q <= acc_q;
		endcase
	end

	// the divider runs only while the sequencer waits on it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == ST_DIV_WAIT))
		else $error("divider busy outside its wait state");

	// a pixel request closes the input channel in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (func == fpn_pkg::FUNC_PIXEL)) |=> !in_ready)
		else $error("input accepted while a pixel is in progress");

	// the total weight is nonzero before normalization
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_START) |-> (w_q != 8'd0))
		else $error("zero octave weight at normalization");

	// a finished pixel never overwrites an unread result
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(pixel_value)))
		else $error("pending pixel overwritten");

endmodule

/* tb/sv/tb_fractal_perlin_noise_pixel_top.sv */
module tb_fractal_perlin_noise_pixel_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NO_TYPED   = -1;
	localparam int DRAIN_CYC  = 250;
	localparam int RAND_ITEMS = 1450;
	localparam int N_PHASE    = 8;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [16:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        func;
	logic [2:0]  table_octave;
	logic [7:0]  table_index;
	logic [7:0]  table_value;
	logic [13:0] pixel_x;
	logic [13:0] pixel_y;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  pixel_value;

	fractal_perlin_noise_pixel_top u_dut (.*);

	typedef struct {
		bit        f;
		bit [2:0]  oct;
		bit [7:0]  idx;
		bit [7:0]  val;
		bit [13:0] x;
		bit [13:0] y;
		int        typed;
	} noise_req_t;

	// model state
	logic [7:0]  perm_copy [0:fpn_pkg::MAX_OCT*256-1];
	logic [16:0] scale_copy;
	logic [3:0]  octs_copy;
	logic [7:0]  pixel_fifo [$];
	int          errors;

	// clock and timeout
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("simulation failed");
		$finish;
	end

	// quintic fade in q16
	function automatic longint fade_q16(longint t);
		longint tt, q32, q16, t3, f;
		tt  = t * t;
		q32 = (longint'(10) << 32) + 6 * tt - ((15 * t) << 16);
		q16 = (q32 + 32768) >> 16;
		t3  = (tt * t + (longint'(1) << 31)) >> 32;
		f   = (t3 * q16 + 32768) >> 16;
		if (f > 65536)
			f = 65536;
		return f;
	endfunction

	function automatic longint grad_dot(logic [7:0] h, longint x, longint y);
		longint a, b;
		a = (h[1] == 1'b0) ? x : y;
		b = (h[1] == 1'b0) ? y : x;
		if (h[0])
			a = -a;
		if (h[1])
			b = -b;
		return a + b;
	endfunction

	function automatic longint lerp_q16(longint a, longint b, longint t);
		return a + ((t * (b - a) + 32768) >>> 16);
	endfunction

	function automatic logic [7:0] perm_at(int oct, int i);
		return perm_copy[oct * 256 + (i & 255)];
	endfunction

	function automatic longint octave_q16(int oct, longint px, longint py);
		longint sx, sy, xf, yf, u, v, x1, x2;
		int xi, yi, ha, hb;
		logic [7:0] aa, ab, ba, bb;
		sx = (px * scale_copy) << oct;
		sy = (py * scale_copy) << oct;
		xi = int'((sx >> 16) & 255);
		yi = int'((sy >> 16) & 255);
		xf = sx & 16'hFFFF;
		yf = sy & 16'hFFFF;
		u  = fade_q16(xf);
		v  = fade_q16(yf);
		ha = int'(perm_at(oct, xi));
		hb = int'(perm_at(oct, xi + 1));
		aa = perm_at(oct, ha + yi);
		ab = perm_at(oct, ha + yi + 1);
		ba = perm_at(oct, hb + yi);
		bb = perm_at(oct, hb + yi + 1);
		x1 = lerp_q16(grad_dot(aa, xf, yf), grad_dot(ba, xf - 65536, yf), u);
		x2 = lerp_q16(grad_dot(ab, xf, yf - 65536),
			grad_dot(bb, xf - 65536, yf - 65536), u);
		return lerp_q16(x1, x2, v);
	endfunction

	// weighted octave sum mapped to 0..255
	function automatic logic [7:0] noise_pixel(logic [13:0] px, logic [13:0] py);
		longint acc, wsum, w, num, den, pix;
		int n;
		acc  = 0;
		wsum = 0;
		n    = int'(octs_copy);
		if (n < 1)
			n = 1;
		if (n > fpn_pkg::MAX_OCT)
			n = fpn_pkg::MAX_OCT;
		for (int o = 0; o < n; o++) begin
			w    = longint'(1) << (fpn_pkg::MAX_OCT - 1 - o);
			acc  += octave_q16(o, longint'(px), longint'(py)) * w;
			wsum += w;
		end
		num = (acc + 65536 * wsum) * 255;
		den = 2 * 65536 * wsum;
		if (num <= 0)
			pix = 0;
		else begin
			pix = num / den;
			if (pix > 255)
				pix = 255;
		end
		return pix[7:0];
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// send one request, predict on acceptance
	task automatic send_req(noise_req_t rq);
		int g;
		g = gap_len();
		if (g > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		func         <= rq.f;
		table_octave <= rq.oct;
		table_index  <= rq.idx;
		table_value  <= rq.val;
		pixel_x      <= rq.x;
		pixel_y      <= rq.y;
		do @(posedge clk); while (!in_ready);
		if (rq.f == fpn_pkg::FUNC_WRITE)
			perm_copy[{rq.oct, rq.idx}] = rq.val;
		else if (rq.typed != NO_TYPED)
			pixel_fifo.push_back(rq.typed[7:0]);
		else
			pixel_fifo.push_back(noise_pixel(rq.x, rq.y));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pixel_fifo.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_regs(logic [16:0] scale, logic [3:0] octs);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= fpn_pkg::CFG_SCALE;
		cfg_data  <= scale;
		@(negedge clk);
		cfg_index <= fpn_pkg::CFG_OCTAVES;
		cfg_data  <= 17'(octs);
		@(negedge clk);
		cfg_we    <= 1'b0;
		scale_copy = scale;
		octs_copy  = octs;
	endtask

	function automatic noise_req_t rand_req();
		noise_req_t rq;
		int r;
		rq.f     = ($urandom_range(0, 99) < 70) ? fpn_pkg::FUNC_PIXEL : fpn_pkg::FUNC_WRITE;
		rq.oct   = 3'($urandom);
		rq.idx   = 8'($urandom);
		rq.val   = 8'($urandom);
		rq.x     = 14'($urandom);
		rq.y     = 14'($urandom);
		rq.typed = NO_TYPED;
		r = $urandom_range(0, 9);
		if (r == 0)
			rq.x = 14'h3FFF;
		else if (r == 1)
			rq.y = 14'h3FFF;
		else if (r == 2)
			rq.x = 14'($urandom_range(0, 63));
		else if (r == 3)
			rq.y = 14'd0;
		return rq;
	endfunction

	// receiver stalls
	initial begin
		int st;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (st > 0) begin
				st--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					st = gap_len();
			end
		end
	end

	// result check
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (pixel_fifo.size() == 0) begin
				$display("%0t: unexpected pixel_value %0d", $time, pixel_value);
				errors++;
			end else begin
				want = pixel_fifo.pop_front();
				if (pixel_value !== want) begin
					$display("%0t: pixel_value expected %0d actual %0d",
						$time, want, pixel_value);
					errors++;
				end
			end
		end
	end

	initial begin
		noise_req_t dir_rows [13];
		noise_req_t rq;
		logic [16:0] ph_scale [N_PHASE];
		logic [3:0]  ph_octs [N_PHASE];
		errors       = 0;
		cfg_we       = 1'b0;
		cfg_index    = 1'b0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		func         = 1'b0;
		table_octave = '0;
		table_index  = '0;
		table_value  = '0;
		pixel_x      = '0;
		pixel_y      = '0;
		scale_copy   = 17'd3277;
		octs_copy    = 4'd4;
		arst_n       = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// load every table so no entry is read unwritten
		for (int a = 0; a < fpn_pkg::MAX_OCT * 256; a++) begin
			rq = '{fpn_pkg::FUNC_WRITE, a[10:8], a[7:0], 8'($urandom), '0, '0, NO_TYPED};
			send_req(rq);
		end

		// directed rows: first under reset settings, then with zero scale
		dir_rows[0]  = '{fpn_pkg::FUNC_WRITE, 3'd7, 8'd255, 8'd255, 14'd0, 14'd0, NO_TYPED};
		dir_rows[1]  = '{fpn_pkg::FUNC_WRITE, 3'd0, 8'd0, 8'd0, 14'd0, 14'd0, NO_TYPED};
		dir_rows[2]  = '{fpn_pkg::FUNC_WRITE, 3'd3, 8'd128, 8'd1, 14'h3FFF, 14'h3FFF,
			NO_TYPED};
		dir_rows[3]  = '{fpn_pkg::FUNC_PIXEL, 3'd0, 8'd0, 8'd0, 14'd0, 14'd0, NO_TYPED};
		dir_rows[4]  = '{fpn_pkg::FUNC_PIXEL, 3'd7, 8'd255, 8'd255, 14'h3FFF, 14'h3FFF,
			NO_TYPED};
		dir_rows[5]  = '{fpn_pkg::FUNC_PIXEL, 3'd0, 8'd0, 8'd0, 14'h3FFF, 14'd0, NO_TYPED};
		dir_rows[6]  = '{fpn_pkg::FUNC_PIXEL, 3'd0, 8'd0, 8'd0, 14'd0, 14'h3FFF, NO_TYPED};
		dir_rows[7]  = '{fpn_pkg::FUNC_PIXEL, 3'd0, 8'd0, 8'd0, 14'd1, 14'd1, NO_TYPED};
		dir_rows[8]  = '{fpn_pkg::FUNC_PIXEL, 3'd0, 8'd0, 8'd0, 14'd8191, 14'd12345,
			NO_TYPED};
		dir_rows[9]  = '{fpn_pkg::FUNC_PIXEL, 3'd0, 8'd0, 8'd0, 14'd0, 14'd0, 127};
		dir_rows[10] = '{fpn_pkg::FUNC_PIXEL, 3'd0, 8'd0, 8'd0, 14'h3FFF, 14'h3FFF, 127};
		dir_rows[11] = '{fpn_pkg::FUNC_PIXEL, 3'd0, 8'd0, 8'd0, 14'd5, 14'd9000, 127};
		dir_rows[12] = '{fpn_pkg::FUNC_PIXEL, 3'd0, 8'd0, 8'd0, 14'h2AAA, 14'h1555, 127};
		for (int k = 0; k < 13; k++) begin
			if (k == 9) begin
				drain();
				// zero scale, octave count zero counts as one
				write_regs(17'd0, 4'd0);
			end
			send_req(dir_rows[k]);
		end

		// random phases over several settings
		ph_scale = '{17'd66, 17'd65536, 17'h1FFFF, 17'd3277, 17'd0, 17'd66,
			17'($urandom_range(66, 65536)), 17'($urandom)};
		ph_octs  = '{4'd1, 4'd8, 4'd15, 4'd4, 4'd8, 4'd8,
			4'($urandom_range(1, 8)), 4'($urandom)};
		for (int p = 0; p < N_PHASE; p++) begin
			drain();
			write_regs(ph_scale[p], ph_octs[p]);
			for (int k = 0; k < RAND_ITEMS / N_PHASE; k++)
				send_req(rand_req());
		end
		drain();

		if (errors == 0 && pixel_fifo.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
